### rtl/swut_pkg.sv
// Shared types and constants for the single-wire UART transceiver.
// No dependencies; every other file imports this package.
`default_nettype none

package swut_pkg;

  localparam int DATA_BITS  = 8;
  localparam int FRAME_BITS = DATA_BITS + 2;
  localparam int TICK_W     = 16;
  localparam int BIT_IDX_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [TICK_W-1:0] MIN_PERIOD   = TICK_W'(4);
  localparam logic [TICK_W-1:0] RESET_PERIOD = TICK_W'(1042);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERTED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LEVEL = 2'd2;

  typedef struct packed {
    logic                 line_level;
    logic                 drive_enable;
    logic                 rx_valid;
    logic [DATA_BITS-1:0] rx_value;
    logic                 tx_busy;
    logic                 tx_done;
  } result_t;

  // Transmitter status toward the top level for the current tick.
  typedef struct packed {
    logic drive;
    logic level;
    logic busy;
    logic done;
    logic take;   // request taken this tick, receiver must drop its frame
  } tx_status_t;

  // Receiver control from the top level.
  typedef struct packed {
    logic step;   // advance the receiver with this tick's sample
    logic clear;  // abandon reception
  } rx_ctrl_t;

endpackage

`default_nettype wire

### rtl/swut_if.sv
// Valid/ready channel interfaces for samples, results and configuration.
// Depends on swut_pkg.
`default_nettype none

interface swut_sample_if import swut_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 line_sample;
  logic                 send_request;
  logic [DATA_BITS-1:0] send_value;

  modport source (output valid, line_sample, send_request, send_value, input ready);
  modport sink   (input valid, line_sample, send_request, send_value, output ready);
endinterface

interface swut_result_if import swut_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 line_level;
  logic                 drive_enable;
  logic                 rx_valid;
  logic [DATA_BITS-1:0] rx_value;
  logic                 tx_busy;
  logic                 tx_done;

  modport source (output valid, line_level, drive_enable, rx_valid, rx_value, tx_busy,
                  tx_done, input ready);
  modport sink   (input valid, line_level, drive_enable, rx_valid, rx_value, tx_busy,
                  tx_done, output ready);
endinterface

interface swut_cfg_if import swut_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/swut_tx.sv
// Transmitter: frame register, bit timer and bit counter.
// Depends on swut_pkg.
`default_nettype none

module swut_tx import swut_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire logic                 send_request,
  input  wire logic [DATA_BITS-1:0] send_value,
  input  wire logic [TICK_W-1:0]    period,
  input  wire logic                 inverted,
  input  wire logic                 idle_level,
  output tx_status_t                status
);

  logic                  active, active_next;
  logic [FRAME_BITS-1:0] frame, frame_next;
  logic [BIT_IDX_W-1:0]  bit_index, bit_index_next;
  logic [TICK_W-1:0]     tick_count, tick_count_next;
  logic [TICK_W-1:0]     tick_inc;
  logic [BIT_IDX_W-1:0]  sel;
  logic                  done, take, level;

  always_comb begin
    active_next     = active;
    frame_next      = frame;
    bit_index_next  = bit_index;
    tick_count_next = tick_count;
    tick_inc        = tick_count + TICK_W'(1);
    done            = 1'b0;
    take            = 1'b0;
    if (active) begin
      tick_count_next = tick_inc;
      if (tick_inc >= period) begin
        tick_count_next = '0;
        if (bit_index < BIT_IDX_W'(FRAME_BITS)) begin
          bit_index_next = bit_index + BIT_IDX_W'(1);
        end else begin
          active_next    = 1'b0;
          bit_index_next = '0;
          done           = 1'b1;
        end
      end
    end else if (send_request) begin
      // Inverted mode: start high, data inverted, stop low.
      frame_next      = inverted ? {1'b0, ~send_value, 1'b1} : {1'b1, send_value, 1'b0};
      active_next     = 1'b1;
      bit_index_next  = '0;
      tick_count_next = '0;
      take            = 1'b1;
    end
  end

  // Bit index zero is the leading idle period; frame bits follow from one.
  always_comb begin
    sel = bit_index_next - BIT_IDX_W'(1);
    if (bit_index_next == '0 || bit_index_next > BIT_IDX_W'(FRAME_BITS)) begin
      level = idle_level;
    end else begin
      level = frame_next[sel];
    end
  end

  assign status.drive = active_next;
  assign status.level = active_next & level;
  assign status.busy  = active_next;
  assign status.done  = done;
  assign status.take  = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      frame      <= '0;
      bit_index  <= '0;
      tick_count <= '0;
    end else if (advance) begin
      active     <= active_next;
      frame      <= frame_next;
      bit_index  <= bit_index_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/swut_rx.sv
// Receiver: phase sequencer, mid-bit timer and data shift register.
// Depends on swut_pkg.
`default_nettype none

module swut_rx import swut_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire rx_ctrl_t             ctrl,
  input  wire logic                 line_sample,
  input  wire logic [TICK_W-1:0]    period,
  input  wire logic                 inverted,
  output logic                      rx_valid,
  output logic [DATA_BITS-1:0]      rx_value
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_DATA,
    PH_STOP
  } rx_phase_t;

  rx_phase_t             phase, phase_next;
  logic [BIT_IDX_W-1:0]  bit_index, bit_index_next;
  logic [DATA_BITS-1:0]  shift, shift_next;
  logic [TICK_W-1:0]     tick_count, tick_count_next;
  logic [TICK_W-1:0]     tick_inc, target;
  logic                  hit, is_start, data_bit;

  always_comb begin
    phase_next      = phase;
    bit_index_next  = bit_index;
    shift_next      = shift;
    tick_count_next = tick_count;
    rx_valid        = 1'b0;
    rx_value        = '0;
    tick_inc        = tick_count + TICK_W'(1);
    // The start bit is checked half a period in, later bits a full period apart.
    target          = (phase == PH_START) ? (period >> 1) : period;
    hit             = (tick_inc >= target);
    is_start        = (line_sample == inverted);
    data_bit        = line_sample ^ inverted;
    if (ctrl.clear) begin
      phase_next      = PH_IDLE;
      tick_count_next = '0;
    end else if (ctrl.step) begin
      if (phase != PH_IDLE) begin
        tick_count_next = hit ? '0 : tick_inc;
      end
      case (phase)
        PH_IDLE: begin
          if (is_start) begin
            phase_next      = PH_START;
            tick_count_next = '0;
          end
        end
        PH_START: begin
          if (hit) begin
            if (is_start) begin
              phase_next     = PH_DATA;
              bit_index_next = '0;
              shift_next     = '0;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
        PH_DATA: begin
          if (hit) begin
            if (bit_index < BIT_IDX_W'(DATA_BITS)) begin
              shift_next[bit_index[$clog2(DATA_BITS)-1:0]] = data_bit;
            end
            bit_index_next = bit_index + BIT_IDX_W'(1);
            if (bit_index_next >= BIT_IDX_W'(DATA_BITS)) begin
              phase_next = PH_STOP;
            end
          end
        end
        PH_STOP: begin
          if (hit) begin
            if (!is_start) begin
              rx_valid = 1'b1;
              rx_value = shift;
            end
            phase_next = PH_IDLE;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_index  <= '0;
      shift      <= '0;
      tick_count <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      shift      <= shift_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/swut_out_buf.sv
// Two-entry result buffer that decouples the result channel from the sample side.
// Depends on swut_pkg.
`default_nettype none

module swut_out_buf import swut_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         space,
  output logic         head_valid,
  output result_t      head_data,
  input  wire logic    pop
);

  result_t    entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign space      = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = entries[rd_ptr];
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

### rtl/single_wire_uart_transceiver_core.sv
// Top level of the half-duplex single-wire 8N1 UART transceiver.
// Depends on swut_pkg, swut_if, swut_tx, swut_rx and swut_out_buf.
//
//   Channel  Dir  Transfer moves
//   sample   in   one clock tick: line_sample, send_request, send_value
//   result   out  one result per tick: drive, receive and transmit status
//   cfg      in   register write: index, data (bit period, polarity, idle level)
//
// One sample is taken per cycle; its result is in the output buffer the next
// cycle. The two-entry buffer sets the stall behavior: a sample is still taken
// while one result waits, and sampling stops only when both entries are full.
// Reset is synchronous and restores all registers but the result buffer entries to their reset values.
// The configuration channel is always ready.
`default_nettype none

module single_wire_uart_transceiver_core import swut_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  swut_sample_if.sink  sample,
  swut_result_if.source result,
  swut_cfg_if.sink     cfg
);

  logic [TICK_W-1:0] bit_period;
  logic              inverted_polarity;
  logic              idle_level;
  logic [TICK_W-1:0] period;
  logic              advance;
  logic              space;
  tx_status_t        tx_status;
  rx_ctrl_t          rx_ctrl;
  logic              rx_valid;
  logic [DATA_BITS-1:0] rx_value;
  result_t           res, head;
  logic              head_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period        <= RESET_PERIOD;
      inverted_polarity <= 1'b1;
      idle_level        <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_BIT_PERIOD: bit_period        <= cfg.data[TICK_W-1:0];
        CFG_INVERTED:   inverted_polarity <= cfg.data[0];
        CFG_IDLE_LEVEL: idle_level        <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Periods below the minimum act as the minimum.
  assign period = (bit_period < MIN_PERIOD) ? MIN_PERIOD : bit_period;

  assign sample.ready = space;
  assign advance      = sample.valid & space;

  swut_tx u_tx (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .send_request (sample.send_request),
    .send_value   (sample.send_value),
    .period       (period),
    .inverted     (inverted_polarity),
    .idle_level   (idle_level),
    .status       (tx_status)
  );

  // The receiver only listens while the transmitter neither runs nor starts.
  assign rx_ctrl.clear = tx_status.take;
  assign rx_ctrl.step  = ~tx_status.take & ~tx_status.busy & ~tx_status.done;

  swut_rx u_rx (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .ctrl        (rx_ctrl),
    .line_sample (sample.line_sample),
    .period      (period),
    .inverted    (inverted_polarity),
    .rx_valid    (rx_valid),
    .rx_value    (rx_value)
  );

  always_comb begin
    res.line_level   = tx_status.level;
    res.drive_enable = tx_status.drive;
    res.rx_valid     = rx_valid;
    res.rx_value     = rx_value;
    res.tx_busy      = tx_status.busy;
    res.tx_done      = tx_status.done;
  end

  swut_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (advance),
    .push_data  (res),
    .space      (space),
    .head_valid (head_valid),
    .head_data  (head),
    .pop        (result.ready)
  );

  assign result.valid        = head_valid;
  assign result.line_level   = head.line_level;
  assign result.drive_enable = head.drive_enable;
  assign result.rx_valid     = head.rx_valid;
  assign result.rx_value     = head.rx_value;
  assign result.tx_busy      = head.tx_busy;
  assign result.tx_done      = head.tx_done;

endmodule

`default_nettype wire

### rtl/swut_checker.sv
// Port-level assertions for the transceiver top level, attached by bind.
// Depends on swut_pkg and single_wire_uart_transceiver_core.
`default_nettype none

module swut_checker import swut_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 line_level,
  input wire logic                 drive_enable,
  input wire logic                 rx_valid,
  input wire logic [DATA_BITS-1:0] rx_value,
  input wire logic                 tx_busy,
  input wire logic                 tx_done
);

  // A stalled result stays offered and unchanged.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rx_value) && $stable(line_level)
      && $stable(drive_enable) && $stable(rx_valid) && $stable(tx_busy) && $stable(tx_done))
    else $error("stalled result changed");

  // A byte can only be received while the transmitter leaves the wire alone.
  a_rx_when_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_valid |-> !drive_enable && !tx_busy)
    else $error("byte received while transmitting");

  // The tick that ends a transmission already releases the wire.
  a_done_releases: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_done |-> !tx_busy && !drive_enable && !line_level)
    else $error("wire still driven at end of transmission");

  a_drive_tracks_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_enable == tx_busy) && (drive_enable || !line_level))
    else $error("drive enable and busy disagree");

  a_no_value_without_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rx_valid |-> rx_value == '0)
    else $error("received value without valid");

endmodule

bind single_wire_uart_transceiver_core swut_checker u_swut_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .line_level   (result.line_level),
  .drive_enable (result.drive_enable),
  .rx_valid     (result.rx_valid),
  .rx_value     (result.rx_value),
  .tx_busy      (result.tx_busy),
  .tx_done      (result.tx_done)
);

`default_nettype wire
